[src/window_range_filter_top_defines.svh]
// Assertion macros for the window range filter.
`ifndef WINDOW_RANGE_FILTER_TOP_DEFINES_SVH
`define WINDOW_RANGE_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled in reset.
`define WRF_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wrf assertion failed");
// Next-cycle implication, disabled in reset.
`define WRF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wrf assertion failed");
`else
`define WRF_ASSERT_IMPLY(lbl, ante, cons)
`define WRF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[src/wrf_pkg.sv]
// Types and constants shared by the window range filter.
package wrf_pkg;

	localparam int PIXEL_W   = 8;
	localparam int IMG_W_W   = 11;

	typedef logic [PIXEL_W-1:0] pixel_t;
	typedef logic [IMG_W_W-1:0] img_width_t;

	localparam img_width_t IMG_WIDTH_RESET = 11'd1024;

	// Position flags of one pixel inside the image.
	typedef struct packed {
		logic emit;
		logic last;
	} pos_flags_t;

endpackage

[src/wrf_if.sv]
// Stream and configuration channel interfaces of the window range filter.
interface wrf_pixel_if;
	import wrf_pkg::*;
	logic   valid;
	logic   ready;
	pixel_t pixel;
	logic   frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface wrf_result_if;
	import wrf_pkg::*;
	logic   valid;
	logic   ready;
	pixel_t range_value;
	logic   frame_last;

	modport source (output valid, output range_value, output frame_last, input ready);
	modport sink (input valid, input range_value, input frame_last, output ready);
endinterface

interface wrf_cfg_if;
	import wrf_pkg::*;
	logic       valid;
	logic       ready;
	img_width_t image_width;

	modport source (output valid, output image_width, input ready);
	modport sink (input valid, input image_width, output ready);
endinterface

[src/window_range_filter_top.sv]
// Top level of the window range filter: line stores, window and result register.
// A pixel waits in stage s1, its result in the result register; a busy output stalls both.
// One pixel per cycle unless stalled; line stores are read at transfer, written as s1 leaves.
// Reset: counters and valid flags clear, image width returns to 1024.
// Line stores and window columns are not cleared; they are written before being read.
module window_range_filter_top #(
	parameter int WINDOW    = 3,
	parameter int MAX_WIDTH = 1024
) (
	input logic          clk,
	input logic          arst_n,
	wrf_cfg_if.sink      cfg,
	wrf_pixel_if.sink    pixels,
	wrf_result_if.source results
);
	import wrf_pkg::*;

	`include "window_range_filter_top_defines.svh"

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int ROWS = WINDOW - 1;

	img_width_t image_width_q;

	logic          accept, out_free, s1_leave;
	logic [CW-1:0] col;
	pos_flags_t    flags;

	logic          v_s1;
	pixel_t        px_s1;
	logic [CW-1:0] col_s1;
	pos_flags_t    flags_s1;

	pixel_t rdat       [ROWS];
	pixel_t wdat       [ROWS];
	pixel_t fwd_data_q [ROWS];
	logic   fwd_q;
	pixel_t newcol     [WINDOW];

	pixel_t colhi_q [WINDOW-1];
	pixel_t collo_q [WINDOW-1];
	pixel_t col_hi, col_lo, range_value;

	logic   out_valid_q;
	pixel_t range_q;
	logic   last_q;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMG_WIDTH_RESET;
		end else if (cfg.valid) begin
			image_width_q <= cfg.image_width;
		end
	end

	// handshake
	assign out_free     = !out_valid_q || results.ready;
	assign s1_leave     = v_s1 && out_free;
	assign pixels.ready = !v_s1 || out_free;
	assign accept       = pixels.valid && pixels.ready;

	wrf_ctrl #(
		.WINDOW    (WINDOW),
		.MAX_WIDTH (MAX_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.frame_start (pixels.frame_start),
		.image_width (image_width_q),
		.col         (col),
		.flags       (flags)
	);

	// one line store per buffered row, all at the same column
	for (genvar r = 0; r < ROWS; r++) begin : g_line
		wrf_ram #(
			.WIDTH (PIXEL_W),
			.DEPTH (MAX_WIDTH)
		) u_ram (
			.clk     (clk),
			.wr_en   (s1_leave),
			.wr_addr (col_s1),
			.wr_data (wdat[r]),
			.rd_en   (accept),
			.rd_addr (col),
			.rd_data (rdat[r])
		);
	end

	// take the column just written when the read hits the same address
	always_comb begin
		for (int r = 0; r < ROWS; r++) begin
			newcol[r] = fwd_q ? fwd_data_q[r] : rdat[r];
		end
		newcol[ROWS] = px_s1;
		for (int r = 0; r < ROWS; r++) begin
			wdat[r] = newcol[r+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			fwd_q    <= 1'b0;
			flags_s1 <= '0;
		end else begin
			v_s1 <= accept || (v_s1 && !s1_leave);
			if (accept) begin
				fwd_q    <= s1_leave && (col_s1 == col);
				flags_s1 <= flags;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1      <= pixels.pixel;
			col_s1     <= col;
			fwd_data_q <= wdat;
		end
	end

	wrf_range #(
		.WINDOW (WINDOW)
	) u_range (
		.col_px      (newcol),
		.hi_prev     (colhi_q),
		.lo_prev     (collo_q),
		.col_hi      (col_hi),
		.col_lo      (col_lo),
		.range_value (range_value)
	);

	// shift the window's column extremes left and insert the new column
	always_ff @(posedge clk) begin
		if (s1_leave) begin
			for (int c = 0; c < WINDOW - 2; c++) begin
				colhi_q[c] <= colhi_q[c+1];
				collo_q[c] <= collo_q[c+1];
			end
			colhi_q[WINDOW-2] <= col_hi;
			collo_q[WINDOW-2] <= col_lo;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (s1_leave && flags_s1.emit) || (out_valid_q && !results.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_leave && flags_s1.emit) begin
			range_q <= range_value;
			last_q  <= flags_s1.last;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.range_value = range_q;
	assign results.frame_last  = last_q;

	`WRF_ASSERT_IMPLY(a_ready_when_s1_empty, !v_s1, pixels.ready)
	`WRF_ASSERT_IMPLY(a_col_in_range, 1'b1, col < MAX_WIDTH)
	`WRF_ASSERT_IMPLY(a_result_from_s1, $rose(out_valid_q), $past(s1_leave && flags_s1.emit))
	`WRF_ASSERT_NEXT(a_s1_loaded, accept, v_s1 && (flags_s1 == $past(flags)))

endmodule

[src/wrf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module wrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[src/wrf_ctrl.sv]
// Column and row counters with window position flags.
module wrf_ctrl #(
	parameter int WINDOW    = 3,
	parameter int MAX_WIDTH = 1024,
	localparam int CW = $clog2(MAX_WIDTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  logic                frame_start,
	input  wrf_pkg::img_width_t image_width,
	output logic [CW-1:0]       col,
	output wrf_pkg::pos_flags_t flags
);
	import wrf_pkg::*;

	localparam int MW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (IMG_W_W > MW) ? IMG_W_W : MW;

	logic [CW-1:0] col_q, row_q;
	logic [CW-1:0] row_cur;
	logic [EW-1:0] width_ext, w_eff;
	logic [EW-1:0] col_x, row_x, col_inc, row_inc, w_last;
	logic [CW-1:0] col_nxt, row_nxt;

	always_comb begin
		width_ext = EW'(image_width);
		w_eff     = (width_ext > EW'(MAX_WIDTH)) ? EW'(MAX_WIDTH) : width_ext;
		w_last    = w_eff - EW'(1);

		// frame_start clears the position before this pixel is placed
		col     = frame_start ? '0 : col_q;
		row_cur = frame_start ? '0 : row_q;
		col_x   = EW'(col);
		row_x   = EW'(row_cur);
		col_inc = col_x + EW'(1);
		row_inc = row_x + EW'(1);

		flags.emit = (w_eff >= EW'(WINDOW)) && (row_x >= EW'(WINDOW - 1)) &&
			(col_x >= EW'(WINDOW - 1)) && (row_x < w_eff) && (col_x < w_eff);
		flags.last = (w_eff != '0) && (row_x == w_last) && (col_x == w_last);

		// wrap at end of row and end of image; a zero width always wraps
		if (col_inc >= w_eff) begin
			col_nxt = '0;
			row_nxt = (row_inc >= w_eff) ? '0 : CW'(row_inc);
		end else begin
			col_nxt = CW'(col_inc);
			row_nxt = row_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			col_q <= col_nxt;
			row_q <= row_nxt;
		end
	end

endmodule

[src/wrf_range.sv]
// Column max/min reduction and window max minus min.
module wrf_range #(
	parameter int WINDOW = 3
) (
	input  wrf_pkg::pixel_t col_px  [WINDOW],
	input  wrf_pkg::pixel_t hi_prev [WINDOW-1],
	input  wrf_pkg::pixel_t lo_prev [WINDOW-1],
	output wrf_pkg::pixel_t col_hi,
	output wrf_pkg::pixel_t col_lo,
	output wrf_pkg::pixel_t range_value
);
	import wrf_pkg::*;

	pixel_t hi, lo;

	always_comb begin
		col_hi = col_px[0];
		col_lo = col_px[0];
		for (int r = 1; r < WINDOW; r++) begin
			if (col_px[r] > col_hi) col_hi = col_px[r];
			if (col_px[r] < col_lo) col_lo = col_px[r];
		end

		// combine with the older columns still in the window
		hi = col_hi;
		lo = col_lo;
		for (int c = 0; c < WINDOW - 1; c++) begin
			if (hi_prev[c] > hi) hi = hi_prev[c];
			if (lo_prev[c] < lo) lo = lo_prev[c];
		end
		range_value = hi - lo;
	end

endmodule
